FILE: rtl/ttps_pkg.sv
// ----------------------------------------------------------------------------
// ttps_pkg
// Shared types, constants and score helpers for the transposition table
// probe/store unit.
// ----------------------------------------------------------------------------
package ttps_pkg;

    localparam int ENTRIES   = 4096;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int KEY_W     = 64;
    localparam int SCORE_W   = 16;
    localparam int DEPTH_W   = 7;
    localparam int PLY_W     = 7;
    localparam int AGE_W     = 16;
    localparam int MOVE_W    = 32;
    localparam int BOUND_W   = 2;
    localparam int CFG_W     = 16;

    localparam logic signed [SCORE_W-1:0] MATE_BOUND_RST = -16'sd31000;
    localparam logic [AGE_W-1:0]          AGE_RST        = '0;
    localparam logic [AGE_W:0]            AGE_WINDOW     = 17'd3;
    localparam logic signed [17:0]        SCORE_MAX      = 18'sd32767;

    // request codes
    localparam logic MODE_PROBE = 1'b0;
    localparam logic MODE_STORE = 1'b1;

    // config register indexes
    localparam logic CFG_MATE_BOUND  = 1'b0;
    localparam logic CFG_CURRENT_AGE = 1'b1;

    // bound kinds
    localparam logic [BOUND_W-1:0] BOUND_EXACT = 2'd0;
    localparam logic [BOUND_W-1:0] BOUND_UPPER = 2'd1;
    localparam logic [BOUND_W-1:0] BOUND_LOWER = 2'd2;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0]          key;
        logic signed [SCORE_W-1:0] score;
        logic [BOUND_W-1:0]        bound;
        logic [DEPTH_W-1:0]        depth;
        logic [AGE_W-1:0]          age;
        logic [MOVE_W-1:0]         move;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Mate-distance adjustment with saturation to +/-SCORE_MAX.
    // Probe: mated scores move toward zero by ply; store: away from zero.
    function automatic logic signed [SCORE_W-1:0] f_mate_adjust(
        input logic signed [SCORE_W-1:0] score,
        input logic [PLY_W-1:0]          ply,
        input logic signed [SCORE_W-1:0] mate_bound,
        input logic                      probe
    );
        logic signed [17:0] s;
        logic signed [17:0] p;
        logic signed [17:0] mb;
        logic signed [17:0] nmb;
        logic signed [17:0] adj;
        s   = {{2{score[SCORE_W-1]}}, score};
        p   = {11'b0, ply};
        mb  = {{2{mate_bound[SCORE_W-1]}}, mate_bound};
        nmb = -mb;
        if (s < mb) begin
            adj = probe ? s + p : s - p;
        end else if (s > nmb) begin
            adj = probe ? s - p : s + p;
        end else begin
            adj = s;
        end
        if (adj > SCORE_MAX) begin
            adj = SCORE_MAX;
        end else if (adj < -SCORE_MAX) begin
            adj = -SCORE_MAX;
        end
        return adj[SCORE_W-1:0];
    endfunction

endpackage

FILE: rtl/ttps_ram.sv
// ----------------------------------------------------------------------------
// ttps_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. A read of the address written in the same cycle
// returns the old contents.
// ----------------------------------------------------------------------------
module ttps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/transposition_table_probe_store_unit.sv
// ----------------------------------------------------------------------------
// transposition_table_probe_store_unit
// Direct-mapped search hash table: probe with mate/bound checks, store with
// age- and depth-preferred replacement.
// ----------------------------------------------------------------------------
// After reset the unit sweeps the table to zero, one entry per cycle, over
// all ENTRIES (4096) slots; in_ready stays low during the sweep, config writes
// are taken. Afterwards it takes one probe or store beat per cycle unless the
// output stalls: the table RAM is read at accept, the entry is checked in
// stage 1 and written back as stage 1 advances, and the result is then
// registered in the output register. A back-to-back beat to the same slot
// picks up the just-written entry through a forwarding register. Throughput
// is bounded only by the output handshake.
module transposition_table_probe_store_unit
    import ttps_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // config
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_index,
    input  logic [CFG_W-1:0]          i_cfg_data,
    // request
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_mode,
    input  logic [KEY_W-1:0]          i_position_key,
    input  logic signed [SCORE_W-1:0] i_alpha,
    input  logic signed [SCORE_W-1:0] i_beta,
    input  logic [DEPTH_W-1:0]        i_search_depth,
    input  logic [PLY_W-1:0]          i_ply_from_root,
    input  logic signed [SCORE_W-1:0] i_new_score,
    input  logic [BOUND_W-1:0]        i_bound_kind,
    input  logic [MOVE_W-1:0]         i_best_move,
    // result
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_found,
    output logic signed [SCORE_W-1:0] o_probe_score,
    output logic                      o_stored
);

    t_state r_state, n_state;
    logic [IDX_W-1:0] r_clr_idx;
    logic             clearing;
    logic             clr_last;

    logic signed [SCORE_W-1:0] r_mate_bound;
    logic [AGE_W-1:0]          r_current_age;

    // stage 1: request waiting on RAM data
    logic                      r_s1_vld;
    logic                      r_s1_mode;
    logic [KEY_W-1:0]          r_s1_key;
    logic signed [SCORE_W-1:0] r_s1_alpha;
    logic signed [SCORE_W-1:0] r_s1_beta;
    logic [DEPTH_W-1:0]        r_s1_depth;
    logic [PLY_W-1:0]          r_s1_ply;
    logic signed [SCORE_W-1:0] r_s1_score;
    logic [BOUND_W-1:0]        r_s1_kind;
    logic [MOVE_W-1:0]         r_s1_move;
    logic                      r_fwd_hit;
    t_entry                    r_fwd_entry;

    // output register
    logic                      r_out_vld;
    logic                      r_found;
    logic signed [SCORE_W-1:0] r_probe_score;
    logic                      r_stored;

    logic                      accept;
    logic                      s1_adv;
    logic [IDX_W-1:0]          in_idx;

    logic                      ram_we;
    logic [IDX_W-1:0]          ram_waddr;
    t_entry                    ram_wdata;
    logic [ENTRY_W-1:0]        ram_rdata;

    t_entry                    cur;
    t_entry                    wr_entry;
    logic                      hit;
    logic signed [SCORE_W-1:0] probe_adj;
    logic                      bound_ok;
    logic                      keep;
    logic                      probe_found;
    logic                      do_store;

    // ---------------- control FSM ----------------
    assign clr_last = (r_clr_idx == IDX_W'(ENTRIES - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (clr_last) n_state = ST_RUN;
            ST_RUN:   n_state = ST_RUN;
            default:  n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        case (r_state)
            ST_CLEAR: clearing = 1'b1;
            default:  clearing = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_idx <= '0;
        end else begin
            r_state <= n_state;
            if (clearing) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
        end
    end

    // ---------------- config ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mate_bound  <= MATE_BOUND_RST;
            r_current_age <= AGE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MATE_BOUND:  r_mate_bound  <= $signed(i_cfg_data);
                CFG_CURRENT_AGE: r_current_age <= i_cfg_data;
                default:         ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    assign s1_adv     = r_s1_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !clearing && (!r_s1_vld || s1_adv);
    assign accept     = i_in_valid && o_in_ready;
    assign in_idx     = i_position_key[IDX_W-1:0];

    // ---------------- table RAM ----------------
    always_comb begin
        if (clearing) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_idx;
            ram_wdata = '0;
        end else begin
            ram_we    = s1_adv && do_store;
            ram_waddr = r_s1_key[IDX_W-1:0];
            ram_wdata = wr_entry;
        end
    end

    ttps_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (in_idx),
        .o_rdata (ram_rdata)
    );

    // ---------------- stage 1 ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (accept) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    // the RAM returns stale data when the slot is written in the read cycle
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_mode   <= i_mode;
            r_s1_key    <= i_position_key;
            r_s1_alpha  <= i_alpha;
            r_s1_beta   <= i_beta;
            r_s1_depth  <= i_search_depth;
            r_s1_ply    <= i_ply_from_root;
            r_s1_score  <= i_new_score;
            r_s1_kind   <= i_bound_kind;
            r_s1_move   <= i_best_move;
            r_fwd_hit   <= ram_we && (ram_waddr == in_idx);
            r_fwd_entry <= ram_wdata;
        end
    end

    assign cur = r_fwd_hit ? r_fwd_entry : t_entry'(ram_rdata);

    // probe
    assign hit       = (cur.key == r_s1_key) && (cur.depth >= r_s1_depth);
    assign probe_adj = f_mate_adjust(cur.score, r_s1_ply, r_mate_bound, 1'b1);

    always_comb begin
        case (cur.bound)
            BOUND_EXACT: bound_ok = 1'b1;
            BOUND_UPPER: bound_ok = (probe_adj <= r_s1_alpha);
            BOUND_LOWER: bound_ok = (probe_adj >= r_s1_beta);
            default:     bound_ok = 1'b0;
        endcase
    end

    assign probe_found = (r_s1_mode == MODE_PROBE) && hit && bound_ok;

    // store: resident entry survives when recent and deeper
    assign keep = (({1'b0, cur.age} + AGE_WINDOW) > {1'b0, r_current_age})
                  && (cur.depth > r_s1_depth);
    assign do_store = (r_s1_mode == MODE_STORE) && !keep;

    always_comb begin
        wr_entry.key   = r_s1_key;
        wr_entry.score = f_mate_adjust(r_s1_score, r_s1_ply, r_mate_bound, 1'b0);
        wr_entry.bound = r_s1_kind;
        wr_entry.depth = r_s1_depth;
        wr_entry.age   = r_current_age;
        wr_entry.move  = r_s1_move;
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_found       <= probe_found;
            r_probe_score <= probe_found ? probe_adj : '0;
            r_stored      <= do_store;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_found       = r_found;
    assign o_probe_score = r_probe_score;
    assign o_stored      = r_stored;

endmodule

FILE: tb/tt_probe_store_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tt_probe_store_checker
// Watches the register, request and result ports of the table unit. Keeps a
// shadow copy of the table and both registers. Works out the outcome of each
// accepted request beat and compares every result beat with it, in order.
// ----------------------------------------------------------------------------
module tt_probe_store_checker
    import ttps_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_index,
    input  logic [CFG_W-1:0]          i_cfg_data,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  logic                      i_mode,
    input  logic [KEY_W-1:0]          i_position_key,
    input  logic signed [SCORE_W-1:0] i_alpha,
    input  logic signed [SCORE_W-1:0] i_beta,
    input  logic [DEPTH_W-1:0]        i_search_depth,
    input  logic [PLY_W-1:0]          i_ply_from_root,
    input  logic signed [SCORE_W-1:0] i_new_score,
    input  logic [BOUND_W-1:0]        i_bound_kind,
    input  logic [MOVE_W-1:0]         i_best_move,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic                      i_found,
    input  logic signed [SCORE_W-1:0] i_probe_score,
    input  logic                      i_stored,
    output int                        o_errors,
    output int                        o_pending
);

    localparam int AGE_SLACK = 3;
    localparam int SCORE_LIM = 32767;

    typedef struct packed {
        logic                      found;
        logic signed [SCORE_W-1:0] score;
        logic                      stored;
    } tt_outcome_t;

    t_entry                    shadow [ENTRIES];
    logic signed [SCORE_W-1:0] mate_lim;
    logic [AGE_W-1:0]          gen_now;
    tt_outcome_t               outcomes_due [$];
    tt_outcome_t               want;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        o_errors++;
    endtask

    // Probe pulls mate scores toward zero by ply, store pushes them away.
    function automatic int mate_shift(input int s, input int ply, input bit toward_zero);
        int mb;
        int v;
        mb = mate_lim;
        if (s < mb) begin
            v = toward_zero ? s + ply : s - ply;
        end else if (s > -mb) begin
            v = toward_zero ? s - ply : s + ply;
        end else begin
            v = s;
        end
        if (v > SCORE_LIM) begin
            v = SCORE_LIM;
        end else if (v < -SCORE_LIM) begin
            v = -SCORE_LIM;
        end
        return v;
    endfunction

    function automatic tt_outcome_t table_access(
        input logic                      mode,
        input logic [KEY_W-1:0]          key,
        input logic signed [SCORE_W-1:0] alpha,
        input logic signed [SCORE_W-1:0] beta,
        input logic [DEPTH_W-1:0]        depth,
        input logic [PLY_W-1:0]          ply,
        input logic signed [SCORE_W-1:0] score,
        input logic [BOUND_W-1:0]        kind,
        input logic [MOVE_W-1:0]         move
    );
        tt_outcome_t      r;
        logic [IDX_W-1:0] idx;
        int               adj;
        bit               ok;
        bit               keep;
        r   = '0;
        idx = key[IDX_W-1:0];
        ok  = 1'b0;
        if (mode == MODE_PROBE) begin
            if (shadow[idx].key == key && shadow[idx].depth >= depth) begin
                adj = mate_shift($signed(shadow[idx].score), ply, 1'b1);
                case (shadow[idx].bound)
                    BOUND_EXACT: ok = 1'b1;
                    BOUND_UPPER: ok = (adj <= alpha);
                    BOUND_LOWER: ok = (adj >= beta);
                    default:     ok = 1'b0;   // unused kind never answers
                endcase
                if (ok) begin
                    r.found = 1'b1;
                    r.score = adj[SCORE_W-1:0];
                end
            end
        end else begin
            // age test is signed: the window may reach below zero
            keep = (int'(shadow[idx].age) > int'(gen_now) - AGE_SLACK)
                   && (shadow[idx].depth > depth);
            if (!keep) begin
                shadow[idx].key   = key;
                shadow[idx].score = 16'(mate_shift(score, ply, 1'b0));
                shadow[idx].bound = kind;
                shadow[idx].depth = depth;
                shadow[idx].age   = gen_now;
                shadow[idx].move  = move;
                r.stored = 1'b1;
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (shadow[n]) shadow[n] = '0;
            mate_lim = MATE_BOUND_RST;
            gen_now  = AGE_RST;
            outcomes_due.delete();
            o_errors  = 0;
            o_pending = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MATE_BOUND:  mate_lim = i_cfg_data;
                    CFG_CURRENT_AGE: gen_now  = i_cfg_data;
                    default:         ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (outcomes_due.size() == 0) begin
                    report_mismatch("result beat with no request outstanding");
                end else begin
                    want = outcomes_due.pop_front();
                    if (i_found !== want.found) begin
                        report_mismatch($sformatf("found %b, expected %b",
                                                  i_found, want.found));
                    end
                    if (i_probe_score !== want.score) begin
                        report_mismatch($sformatf("probe_score %0d, expected %0d",
                                                  i_probe_score, want.score));
                    end
                    if (i_stored !== want.stored) begin
                        report_mismatch($sformatf("stored %b, expected %b",
                                                  i_stored, want.stored));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                outcomes_due.push_back(table_access(i_mode, i_position_key, i_alpha,
                                                    i_beta, i_search_depth,
                                                    i_ply_from_root, i_new_score,
                                                    i_bound_kind, i_best_move));
            end
            o_pending = outcomes_due.size();
        end
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the transposition table unit: a directed pass over the field
// extremes and corner cases, then random probe/store traffic over a small
// key pool in several register settings, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb;
    import ttps_pkg::*;

    localparam int          CYCLE_LIMIT     = 400000;
    localparam int          PHASES          = 7;
    localparam int          ITEMS_PER_PHASE = 125;
    localparam int          RX_HOLD_CYCLES  = 64;
    localparam int          SETTLE_CYCLES   = 16;
    localparam int          TAGS            = 4;
    localparam int          SLOTS           = 6;
    localparam int          TAG_W           = KEY_W - IDX_W;
    localparam logic [BOUND_W-1:0] BOUND_UNUSED = 2'd3;

    // same low bits in KEY_A and KEY_A2: they share one slot
    localparam logic [KEY_W-1:0] KEY_A  = 64'h0123_4567_89AB_C123;
    localparam logic [KEY_W-1:0] KEY_A2 = 64'hFEDC_BA98_7654_3123;
    localparam logic [KEY_W-1:0] KEY_B  = 64'h5A5A_A5A5_0F0F_F456;
    localparam logic [KEY_W-1:0] KEY_C  = 64'h8000_0000_0000_0789;
    localparam logic [KEY_W-1:0] KEY_D  = 64'h0000_0001_2345_6ABC;
    localparam logic [KEY_W-1:0] KEY_E  = 64'h7FFF_FFFF_FFFF_FDEF;
    localparam logic [KEY_W-1:0] KEY_F  = 64'h1357_9BDF_2468_AF00;

    typedef struct packed {
        logic                      mode;
        logic [KEY_W-1:0]          key;
        logic signed [SCORE_W-1:0] alpha;
        logic signed [SCORE_W-1:0] beta;
        logic [DEPTH_W-1:0]        depth;
        logic [PLY_W-1:0]          ply;
        logic signed [SCORE_W-1:0] score;
        logic [BOUND_W-1:0]        kind;
        logic [MOVE_W-1:0]         move;
    } tt_request_t;

    logic                      i_clk           = 1'b0;
    logic                      i_rst_n         = 1'b0;
    logic                      i_cfg_we        = 1'b0;
    logic                      i_cfg_index     = CFG_MATE_BOUND;
    logic [CFG_W-1:0]          i_cfg_data      = '0;
    logic                      i_in_valid      = 1'b0;
    logic                      i_mode          = MODE_PROBE;
    logic [KEY_W-1:0]          i_position_key  = '0;
    logic signed [SCORE_W-1:0] i_alpha         = '0;
    logic signed [SCORE_W-1:0] i_beta          = '0;
    logic [DEPTH_W-1:0]        i_search_depth  = '0;
    logic [PLY_W-1:0]          i_ply_from_root = '0;
    logic signed [SCORE_W-1:0] i_new_score     = '0;
    logic [BOUND_W-1:0]        i_bound_kind    = BOUND_EXACT;
    logic [MOVE_W-1:0]         i_best_move     = '0;
    logic                      i_out_ready     = 1'b0;
    logic                      o_in_ready;
    logic                      o_out_valid;
    logic                      o_found;
    logic signed [SCORE_W-1:0] o_probe_score;
    logic                      o_stored;

    int                        errors;
    int                        pending;
    int unsigned               cycle_count = 0;
    int unsigned               hold_reqs   = 0;
    int unsigned               hold_seen;
    bit                        tail_quiet  = 1'b0;
    int                        rx_hold;
    int                        rx_gap;
    int                        rx_calm;
    int                        tx_calm     = 0;
    logic [TAG_W-1:0]          tag_pool   [TAGS];
    logic [IDX_W-1:0]          slot_pool  [SLOTS];
    int                        phase_mate [PHASES];
    int                        phase_age  [PHASES];

    transposition_table_probe_store_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_position_key  (i_position_key),
        .i_alpha         (i_alpha),
        .i_beta          (i_beta),
        .i_search_depth  (i_search_depth),
        .i_ply_from_root (i_ply_from_root),
        .i_new_score     (i_new_score),
        .i_bound_kind    (i_bound_kind),
        .i_best_move     (i_best_move),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_found         (o_found),
        .o_probe_score   (o_probe_score),
        .o_stored        (o_stored)
    );

    tt_probe_store_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_position_key  (i_position_key),
        .i_alpha         (i_alpha),
        .i_beta          (i_beta),
        .i_search_depth  (i_search_depth),
        .i_ply_from_root (i_ply_from_root),
        .i_new_score     (i_new_score),
        .i_bound_kind    (i_bound_kind),
        .i_best_move     (i_best_move),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_found         (o_found),
        .i_probe_score   (o_probe_score),
        .i_stored        (o_stored),
        .o_errors        (errors),
        .o_pending       (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("transposition_table_probe_store_unit regression: fail");
            $finish;
        end
    end

    // Result side: short random stalls, calm stretches, and a long hold on
    // request so the unit backs up into its request port.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            hold_seen = 0;
            rx_hold   = 0;
            rx_gap    = 0;
            rx_calm   = 0;
        end else if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            rx_hold   = RX_HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold--;
            i_out_ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            i_out_ready <= 1'b0;
        end else if (tail_quiet || rx_calm > 0) begin
            if (rx_calm > 0) rx_calm--;
            i_out_ready <= 1'b1;
        end else begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    rx_gap = $urandom_range(0, 3);
                    i_out_ready <= 1'b0;
                end
                2: begin
                    rx_calm = $urandom_range(10, 40);
                    i_out_ready <= 1'b1;
                end
                default: i_out_ready <= 1'b1;
            endcase
        end
    end

    function automatic logic signed [SCORE_W-1:0] draw_score();
        int v;
        case ($urandom_range(0, 3))
            0:       v = -int'($urandom_range(29000, 32767));
            1:       v = int'($urandom_range(29000, 32767));
            default: v = int'($urandom_range(0, 65534)) - 32767;
        endcase
        return v[SCORE_W-1:0];
    endfunction

    // Mostly keys from a small pool so stores and probes meet in the same
    // slots, with colliding tags; now and then a stray key.
    function automatic tt_request_t random_request();
        tt_request_t r;
        r.mode  = $urandom_range(0, 1) ? MODE_STORE : MODE_PROBE;
        r.key   = {tag_pool[$urandom_range(0, TAGS - 1)],
                   slot_pool[$urandom_range(0, SLOTS - 1)]};
        if ($urandom_range(0, 9) == 0) r.key = {$urandom, $urandom};
        r.alpha = draw_score();
        r.beta  = draw_score();
        r.depth = ($urandom_range(0, 3) == 0) ? DEPTH_W'($urandom_range(0, 127))
                                               : DEPTH_W'($urandom_range(0, 15));
        r.ply   = PLY_W'($urandom_range(0, 127));
        r.score = draw_score();
        r.kind  = ($urandom_range(0, 9) == 0) ? BOUND_UNUSED : 2'($urandom_range(0, 2));
        r.move  = $urandom;
        return r;
    endfunction

    task automatic push_request(input tt_request_t r);
        i_in_valid      <= 1'b1;
        i_mode          <= r.mode;
        i_position_key  <= r.key;
        i_alpha         <= r.alpha;
        i_beta          <= r.beta;
        i_search_depth  <= r.depth;
        i_ply_from_root <= r.ply;
        i_new_score     <= r.score;
        i_bound_kind    <= r.kind;
        i_best_move     <= r.move;
        do @(posedge i_clk); while (!o_in_ready);
        if (tx_calm > 0) begin
            tx_calm--;
        end else if (!tail_quiet) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    i_in_valid     <= 1'b0;
                    i_mode         <= 1'($urandom_range(0, 1));
                    i_position_key <= {$urandom, $urandom};
                    repeat ($urandom_range(1, 4)) @(posedge i_clk);
                end
                2:       tx_calm = $urandom_range(10, 40);
                default: ;
            endcase
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic load_settings(input logic [CFG_W-1:0] mate, input logic [CFG_W-1:0] age);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_MATE_BOUND;
        i_cfg_data  <= mate;
        @(posedge i_clk);
        i_cfg_index <= CFG_CURRENT_AGE;
        i_cfg_data  <= age;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        for (int t = 2; t < TAGS; t++) tag_pool[t] = TAG_W'({$urandom, $urandom});
        slot_pool[0] = '0;
        slot_pool[1] = '1;
        for (int s = 2; s < SLOTS; s++) slot_pool[s] = IDX_W'($urandom);
        phase_mate = '{-32767, 0, -31000, -100, -20000, 0, -31000};
        phase_age  = '{1, 3, 4, 65535, 0, 2, 6};
        phase_mate[5] = -int'($urandom_range(0, 32767));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: mate bound -31000, age 0
        // cleared slots hold key zero at depth zero
        push_request('{MODE_PROBE, '0, -32767, 32767, 0, 0, 0, BOUND_EXACT, '0});
        push_request('{MODE_PROBE, '0, -32767, 32767, 1, 0, 0, BOUND_EXACT, '0});
        push_request('{MODE_PROBE, '1, 32767, -32767, 0, 127, 0, BOUND_EXACT, '0});
        // saturating store, then a recent deeper entry refuses a shallow one
        push_request('{MODE_STORE, '1, 32767, -32767, 127, 127, 32767, BOUND_EXACT, '1});
        push_request('{MODE_PROBE, '1, 0, 0, 127, 127, 0, BOUND_EXACT, '0});
        push_request('{MODE_STORE, '1, 0, 0, 0, 0, -5, BOUND_LOWER, '0});
        // upper bound against alpha, depth short of the stored one
        push_request('{MODE_STORE, KEY_A, 0, 0, 10, 127, -32767, BOUND_UPPER, 32'h1});
        push_request('{MODE_PROBE, KEY_A, -32767, 0, 10, 0, 0, BOUND_EXACT, '0});
        push_request('{MODE_PROBE, KEY_A, -32767, 0, 10, 127, 0, BOUND_EXACT, '0});
        push_request('{MODE_PROBE, KEY_A, 32767, 0, 11, 0, 0, BOUND_EXACT, '0});
        // lower bound against beta, on and just past the edge
        push_request('{MODE_STORE, KEY_B, 0, 0, 5, 50, 100, BOUND_LOWER, 32'h2});
        push_request('{MODE_PROBE, KEY_B, 0, 100, 5, 50, 0, BOUND_EXACT, '0});
        push_request('{MODE_PROBE, KEY_B, 0, 101, 5, 50, 0, BOUND_EXACT, '0});
        push_request('{MODE_STORE, KEY_C, 0, 0, 3, 0, 5, BOUND_UNUSED, 32'h3});
        push_request('{MODE_PROBE, KEY_C, 32767, -32767, 0, 0, 0, BOUND_EXACT, '0});
        // mate bound edges
        push_request('{MODE_STORE, KEY_D, 0, 0, 2, 1, -31001, BOUND_EXACT, 32'h4});
        push_request('{MODE_PROBE, KEY_D, 0, 0, 2, 1, 0, BOUND_EXACT, '0});
        push_request('{MODE_STORE, KEY_E, 0, 0, 2, 5, 31001, BOUND_EXACT, 32'h5});
        push_request('{MODE_PROBE, KEY_E, 0, 0, 2, 5, 0, BOUND_EXACT, '0});
        push_request('{MODE_STORE, KEY_F, 0, 0, 2, 9, -31000, BOUND_EXACT, 32'h6});
        push_request('{MODE_PROBE, KEY_F, 0, 0, 2, 9, 0, BOUND_EXACT, '0});
        // another key in KEY_A's slot: refused when shallower, taken when equal
        push_request('{MODE_STORE, KEY_A2, 0, 0, 0, 0, 7, BOUND_EXACT, 32'h7});
        push_request('{MODE_STORE, KEY_A2, 0, 0, 10, 0, 7, BOUND_EXACT, 32'h8});
        push_request('{MODE_PROBE, KEY_A, 32767, -32767, 0, 0, 0, BOUND_EXACT, '0});

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_results();
            load_settings(CFG_W'(phase_mate[ph]), CFG_W'(phase_age[ph]));
            if (ph == 1 || ph == 4) hold_reqs <= hold_reqs + 1;
            if (ph == PHASES - 1) tail_quiet <= 1'b1;
            repeat (ITEMS_PER_PHASE) push_request(random_request());
        end
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (errors == 0) begin
            $display("transposition_table_probe_store_unit regression: pass");
        end else begin
            $display("transposition_table_probe_store_unit regression: fail");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/ttps_pkg.sv
rtl/ttps_ram.sv
rtl/transposition_table_probe_store_unit.sv
tb/tt_probe_store_checker.sv
tb/tb.sv
